>>> hdl/bsap_pkg.sv
// Shared types and constants for the sensor advertisement parser.
// No dependencies; bsap_front, bsap_queue, bsap_back and the top level import it.
package bsap_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN  = 2'd1;

  localparam logic [47:0] MATCH_ADDR_RST = 48'hA4C1_38A0_0D98;
  localparam logic        FILTER_EN_RST  = 1'b1;

  // AD structure and object codes
  localparam logic [7:0]  AD_SERVICE_DATA = 8'h16;
  localparam logic [15:0] UUID_BTHOME     = 16'hFCD2;
  localparam logic [7:0]  OBJ_PACKET_ID   = 8'h00;
  localparam logic [7:0]  OBJ_BATTERY     = 8'h01;
  localparam logic [7:0]  OBJ_TEMP        = 8'h02;
  localparam logic [7:0]  OBJ_HUMID       = 8'h03;
  localparam logic [7:0]  SVC_MIN_PAYLOAD = 8'd3;

  typedef enum logic [2:0] {
    WALK_LEN,
    WALK_TYPE,
    WALK_SKIP,
    WALK_SVC,
    WALK_DONE
  } walk_phase_t;

  typedef enum logic [2:0] {
    OBJ_ID,
    OBJ_PID,
    OBJ_BAT,
    OBJ_TLO,
    OBJ_THI,
    OBJ_HLO,
    OBJ_HHI
  } obj_phase_t;

  // One decoded reading, as moved through the result queue
  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic               temperature_ok;
    logic [15:0]        humidity_centi;
    logic               humidity_ok;
    logic [7:0]         battery_level;
    logic               battery_ok;
    logic               encrypted_flag;
    logic [47:0]        source_address;
    logic [31:0]        seen_time_ms;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hdl/bsap_front.sv
// Byte-level parse engine: address filter, AD field walk, object decode.
// Depends on bsap_pkg; pushes finished readings into bsap_queue.
module bsap_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_fire,
  input  logic [7:0]       adv_byte,
  input  logic             first_byte,
  input  logic             last_byte,
  input  logic [47:0]      sender_address,
  input  logic [31:0]      time_ms,
  input  logic [47:0]      cfg_target,
  input  logic             cfg_filter,
  output logic             push,
  output bsap_pkg::result_t push_data
);
  import bsap_pkg::*;

  walk_phase_t        walk_r, walk_nxt, walk_eff;
  obj_phase_t         obj_r, obj_nxt;
  logic               acc_r, acc_nxt;
  logic [7:0]         rem_r, rem_nxt, rem_dec;
  logic [1:0]         pos_r, pos_nxt;
  logic [7:0]         uuid_lo_r, uuid_lo_nxt;
  logic [7:0]         obj_lo_r, obj_lo_nxt;
  logic               halt_r, halt_nxt;
  logic signed [15:0] temp_r, temp_nxt;
  logic [15:0]        hum_r, hum_nxt;
  logic [7:0]         bat_r, bat_nxt;
  logic               tok_r, tok_nxt;
  logic               hok_r, hok_nxt;
  logic               bok_r, bok_nxt;
  logic               enc_r, enc_nxt;
  logic [47:0]        addr_r, addr_nxt;

  always_comb begin
    walk_nxt    = walk_r;
    obj_nxt     = obj_r;
    acc_nxt     = acc_r;
    rem_nxt     = rem_r;
    pos_nxt     = pos_r;
    uuid_lo_nxt = uuid_lo_r;
    obj_lo_nxt  = obj_lo_r;
    halt_nxt    = halt_r;
    temp_nxt    = temp_r;
    hum_nxt     = hum_r;
    bat_nxt     = bat_r;
    tok_nxt     = tok_r;
    hok_nxt     = hok_r;
    bok_nxt     = bok_r;
    enc_nxt     = enc_r;
    addr_nxt    = addr_r;
    walk_eff    = walk_r;
    push        = 1'b0;
    rem_dec     = rem_r - 8'd1;

    if (byte_fire) begin
      if (first_byte) begin
        addr_nxt = sender_address;
        acc_nxt  = !cfg_filter || (sender_address == cfg_target);
        walk_eff = WALK_LEN;
      end
      if (!acc_nxt) begin
        walk_nxt = WALK_DONE;
      end else begin
        unique case (walk_eff)
          WALK_LEN: begin
            if (adv_byte == 8'd0) begin
              walk_nxt = WALK_DONE;
            end else begin
              rem_nxt  = adv_byte;
              walk_nxt = WALK_TYPE;
            end
          end
          WALK_TYPE: begin
            rem_nxt = rem_dec;
            if (adv_byte == AD_SERVICE_DATA && rem_dec >= SVC_MIN_PAYLOAD) begin
              walk_nxt = WALK_SVC;
              pos_nxt  = 2'd0;
              obj_nxt  = OBJ_ID;
              halt_nxt = 1'b0;
              temp_nxt = '0;
              hum_nxt  = '0;
              bat_nxt  = '0;
              tok_nxt  = 1'b0;
              hok_nxt  = 1'b0;
              bok_nxt  = 1'b0;
              enc_nxt  = 1'b0;
            end else if (rem_dec == 8'd0) begin
              walk_nxt = WALK_LEN;
            end else begin
              walk_nxt = WALK_SKIP;
            end
          end
          WALK_SKIP: begin
            rem_nxt = rem_dec;
            if (rem_dec == 8'd0) walk_nxt = WALK_LEN;
          end
          WALK_SVC: begin
            rem_nxt = rem_dec;
            unique case (pos_r)
              2'd0: uuid_lo_nxt = adv_byte;
              2'd1: if ({adv_byte, uuid_lo_r} != UUID_BTHOME) halt_nxt = 1'b1;
              2'd2: if (!halt_r && adv_byte[0]) enc_nxt = 1'b1;
              default: begin
                if (!halt_r) begin
                  unique case (obj_r)
                    OBJ_ID: begin
                      priority if (adv_byte == OBJ_PACKET_ID) obj_nxt = OBJ_PID;
                      else if (adv_byte == OBJ_BATTERY)       obj_nxt = OBJ_BAT;
                      else if (adv_byte == OBJ_TEMP)          obj_nxt = OBJ_TLO;
                      else if (adv_byte == OBJ_HUMID)         obj_nxt = OBJ_HLO;
                      else                                    halt_nxt = 1'b1;
                    end
                    OBJ_PID: obj_nxt = OBJ_ID;
                    OBJ_BAT: begin
                      bat_nxt = adv_byte;
                      bok_nxt = 1'b1;
                      obj_nxt = OBJ_ID;
                    end
                    OBJ_TLO: begin
                      obj_lo_nxt = adv_byte;
                      obj_nxt    = OBJ_THI;
                    end
                    OBJ_THI: begin
                      temp_nxt = {adv_byte, obj_lo_r};
                      tok_nxt  = 1'b1;
                      obj_nxt  = OBJ_ID;
                    end
                    OBJ_HLO: begin
                      obj_lo_nxt = adv_byte;
                      obj_nxt    = OBJ_HHI;
                    end
                    OBJ_HHI: begin
                      hum_nxt = {adv_byte, obj_lo_r};
                      hok_nxt = 1'b1;
                      obj_nxt = OBJ_ID;
                    end
                    default: halt_nxt = 1'b1;
                  endcase
                end
              end
            endcase
            if (pos_r != 2'd3) pos_nxt = pos_r + 2'd1;
            if (rem_dec == 8'd0) begin
              walk_nxt = WALK_LEN;
              push     = tok_nxt || hok_nxt || bok_nxt;
            end
          end
          default: ;
        endcase
        if (last_byte) walk_nxt = WALK_DONE;
      end
    end

    push_data.temperature_centi = temp_nxt;
    push_data.temperature_ok    = tok_nxt;
    push_data.humidity_centi    = hum_nxt;
    push_data.humidity_ok       = hok_nxt;
    push_data.battery_level     = bat_nxt;
    push_data.battery_ok        = bok_nxt;
    push_data.encrypted_flag    = enc_nxt;
    push_data.source_address    = addr_nxt;
    push_data.seen_time_ms      = time_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r <= WALK_LEN;
      obj_r  <= OBJ_ID;
      acc_r  <= 1'b0;
      rem_r  <= '0;
      pos_r  <= '0;
      halt_r <= 1'b0;
      tok_r  <= 1'b0;
      hok_r  <= 1'b0;
      bok_r  <= 1'b0;
      enc_r  <= 1'b0;
    end else begin
      walk_r <= walk_nxt;
      obj_r  <= obj_nxt;
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
      pos_r  <= pos_nxt;
      halt_r <= halt_nxt;
      tok_r  <= tok_nxt;
      hok_r  <= hok_nxt;
      bok_r  <= bok_nxt;
      enc_r  <= enc_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    uuid_lo_r <= uuid_lo_nxt;
    obj_lo_r  <= obj_lo_nxt;
    temp_r    <= temp_nxt;
    hum_r     <= hum_nxt;
    bat_r     <= bat_nxt;
    addr_r    <= addr_nxt;
  end

endmodule

>>> hdl/bsap_queue.sv
// Small FIFO of finished readings between parse engine and output stage.
// Depends on bsap_pkg for result_t and q_status_t.
module bsap_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bsap_pkg::result_t   push_data,
  input  logic                pop,
  output bsap_pkg::result_t   head,
  output bsap_pkg::q_status_t status
);
  import bsap_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

endmodule

>>> hdl/bsap_back.sv
// Output register stage: pulls readings from the queue, holds them under stall.
// Depends on bsap_pkg.
module bsap_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bsap_pkg::q_status_t status,
  input  bsap_pkg::result_t   head,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output bsap_pkg::result_t   out_data
);
  import bsap_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;
  logic    load;

  assign load      = !valid_r || !out_stall;
  assign pop       = load && !status.empty;
  assign valid_nxt = load ? !status.empty : valid_r;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) data_r <= head;
  end

endmodule

>>> hdl/ble_sensor_advert_parser.sv
// Top level of the sensor advertisement parser: config registers and wiring
// of bsap_front, bsap_queue and bsap_back. Depends on bsap_pkg.
//
// Usage
//   Input channel (in_*): one advertisement byte per word, with first/last
//   markers, sender address (sampled on the first byte) and a ms timestamp.
//   A word moves when in_valid is high and in_stall is low.
//   Output channel (out_*): one decoded sensor reading per word, moved when
//   out_valid is high and out_stall is low. Value fields read 0 when their
//   _ok bit is 0.
//   Config channel (cfg_*): cfg_ready is always high; index 0 is the 48-bit
//   target address, index 1 the filter enable. Other indexes are ignored.
//   Writes take effect from the next advertisement start.
// Throughput: one byte per cycle while in_stall is low. Each byte steps the parse
//   engine once; the result queue absorbs output back-pressure.
// Result path: a reading is written into the queue on the edge that accepts the
//   byte closing its service-data field, then loaded into the output register when free.
// Stall: in_stall rises only when the result queue is full, which needs
//   QUEUE_DEPTH readings waiting behind a stalled output register.
// Reset: synchronous, active low. Parser idles until a first_byte word,
//   queue and output register empty, config registers return to defaults.
module ble_sensor_advert_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input byte channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_adv_byte,
  input  logic                          in_first_byte,
  input  logic                          in_last_byte,
  input  logic [47:0]                   in_sender_address,
  input  logic [31:0]                   in_time_ms,
  // reading channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_temperature_centi,
  output logic                          out_temperature_ok,
  output logic [15:0]                   out_humidity_centi,
  output logic                          out_humidity_ok,
  output logic [7:0]                    out_battery_level,
  output logic                          out_battery_ok,
  output logic                          out_encrypted_flag,
  output logic [47:0]                   out_source_address,
  output logic [31:0]                   out_seen_time_ms,
  // config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]                   cfg_data
);
  import bsap_pkg::*;

  logic [47:0] target_r;
  logic        filter_r;
  logic        byte_fire;
  logic        push;
  logic        pop;
  result_t     push_data;
  result_t     head;
  result_t     out_data;
  q_status_t   q_status;

  // config: always ready, writes are registered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= MATCH_ADDR_RST;
      filter_r <= FILTER_EN_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MATCH_ADDR) target_r <= cfg_data;
      if (cfg_index == CFG_FILTER_EN)  filter_r <= cfg_data[0];
    end
  end

  // any byte may finish a reading, so hold off input only when the queue
  // has no free slot
  assign in_stall  = q_status.full;
  assign byte_fire = in_valid && !in_stall;

  bsap_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_fire      (byte_fire),
    .adv_byte       (in_adv_byte),
    .first_byte     (in_first_byte),
    .last_byte      (in_last_byte),
    .sender_address (in_sender_address),
    .time_ms        (in_time_ms),
    .cfg_target     (target_r),
    .cfg_filter     (filter_r),
    .push           (push),
    .push_data      (push_data)
  );

  bsap_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  bsap_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .status    (q_status),
    .head      (head),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_temperature_centi = out_data.temperature_centi;
  assign out_temperature_ok    = out_data.temperature_ok;
  assign out_humidity_centi    = out_data.humidity_centi;
  assign out_humidity_ok       = out_data.humidity_ok;
  assign out_battery_level     = out_data.battery_level;
  assign out_battery_ok        = out_data.battery_ok;
  assign out_encrypted_flag    = out_data.encrypted_flag;
  assign out_source_address    = out_data.source_address;
  assign out_seen_time_ms      = out_data.seen_time_ms;

endmodule

>>> hdl/bsap_checker.sv
// Port-level assertions for ble_sensor_advert_parser, attached by bind.
// Depends only on the top-level ports.
module bsap_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_temperature_centi,
  input logic               out_temperature_ok,
  input logic [15:0]        out_humidity_centi,
  input logic               out_humidity_ok,
  input logic [7:0]         out_battery_level,
  input logic               out_battery_ok,
  input logic [47:0]        out_source_address,
  input logic [31:0]        out_seen_time_ms
);

  // output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a stalled reading stays valid and its value, address and time fields stay put
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_temperature_centi)
      && $stable(out_humidity_centi) && $stable(out_battery_level)
      && $stable(out_source_address) && $stable(out_seen_time_ms))
    else $error("stalled reading changed");

  // a reading is only sent when something was decoded
  a_some_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_ok || out_humidity_ok || out_battery_ok))
    else $error("reading without any decoded value");

  // absent values read as zero
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_ok || out_temperature_centi == 16'sd0)
      && (out_humidity_ok || out_humidity_centi == 16'd0)
      && (out_battery_ok || out_battery_level == 8'd0))
    else $error("absent value not zero");

endmodule

bind ble_sensor_advert_parser bsap_checker u_bsap_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_temperature_centi (out_temperature_centi),
  .out_temperature_ok    (out_temperature_ok),
  .out_humidity_centi    (out_humidity_centi),
  .out_humidity_ok       (out_humidity_ok),
  .out_battery_level     (out_battery_level),
  .out_battery_ok        (out_battery_ok),
  .out_source_address    (out_source_address),
  .out_seen_time_ms      (out_seen_time_ms)
);
